@@ rtl/core/rari_pkg.sv @@
// shared constants for the ray versus axis-aligned rectangle intersection core
package rari_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int UV_FRAC         = 16;
  localparam int UV_W            = UV_FRAC + 1;
  localparam int CFG_IDX_W       = 3;

  typedef enum logic [1:0] {
    AXIS_XY = 2'd0,
    AXIS_YZ = 2'd1,
    AXIS_XZ = 2'd2
  } axis_t;

  localparam logic [CFG_IDX_W-1:0] REG_PLANE_AXIS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_X_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_X_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_Y_LOW   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_Y_HIGH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_Z_LOW   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_Z_HIGH  = 3'd7;

endpackage

@@ rtl/core/rari_div.sv @@
// pipelined restoring divider, one quotient bit per stage, with side payload
module rari_div #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 32,
  parameter int PAY_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [PAY_W-1:0] pay,
  output logic             out_valid,
  output logic [NUM_W-1:0] quot,
  output logic [PAY_W-1:0] pay_out
);

  logic             v_r   [NUM_W];
  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [NUM_W-1:0] nq_r  [NUM_W];
  logic [DEN_W-1:0] den_r [NUM_W];
  logic [PAY_W-1:0] pay_r [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic             v_in;
    logic [DEN_W-1:0] rem_in;
    logic [NUM_W-1:0] nq_in;
    logic [DEN_W-1:0] den_in;
    logic [PAY_W-1:0] pay_in;
    logic [DEN_W:0]   hi_s;
    logic [DEN_W:0]   trial;
    logic [DEN_W-1:0] rem_nxt;
    logic [NUM_W-1:0] nq_nxt;

    if (i == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = '0;
      assign nq_in  = num;
      assign den_in = den;
      assign pay_in = pay;
    end else begin : g_next
      assign v_in   = v_r[i-1];
      assign rem_in = rem_r[i-1];
      assign nq_in  = nq_r[i-1];
      assign den_in = den_r[i-1];
      assign pay_in = pay_r[i-1];
    end

    // shift in the next numerator bit and try a subtract
    always_comb begin
      hi_s  = {rem_in, nq_in[NUM_W-1]};
      trial = hi_s - {1'b0, den_in};
      if (!trial[DEN_W]) begin
        rem_nxt = trial[DEN_W-1:0];
        nq_nxt  = {nq_in[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = hi_s[DEN_W-1:0];
        nq_nxt  = {nq_in[NUM_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= rem_nxt;
        nq_r[i]  <= nq_nxt;
        den_r[i] <= den_in;
        pay_r[i] <= pay_in;
      end
    end
  end

  assign out_valid = v_r[NUM_W-1];
  assign quot      = nq_r[NUM_W-1];
  assign pay_out   = pay_r[NUM_W-1];

endmodule

@@ rtl/core/rari_hit.sv @@
// window test, hit point multiply, and rectangle bounds test (four stages)
module rari_hit import rari_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int FB = FRAC_BITS_DEF,
  parameter int QW = CW + 1 + FB
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic [1:0]           axis,
  input  logic signed [CW-1:0] lo_i [3],
  input  logic signed [CW-1:0] hi_i [3],
  input  logic                 in_valid,
  input  logic                 in_ok,
  input  logic                 in_neg,
  input  logic [QW-1:0]        in_q,
  input  logic signed [CW-1:0] in_oa,
  input  logic signed [CW-1:0] in_ob,
  input  logic signed [CW-1:0] in_da,
  input  logic signed [CW-1:0] in_db,
  input  logic signed [CW-1:0] in_tmin,
  input  logic signed [CW-1:0] in_tmax,
  output logic                 out_valid,
  output logic                 out_hit,
  output logic signed [CW-1:0] out_t,
  output logic [CW:0]          out_num_u,
  output logic [CW:0]          out_span_u,
  output logic                 out_zero_u,
  output logic [CW:0]          out_num_v,
  output logic [CW:0]          out_span_v,
  output logic                 out_zero_v
);

  localparam int PW = 2 * CW - FB + 1;

  // stage 1: signed t and window test
  logic signed [QW:0] t_full;
  logic signed [QW:0] tmin_x;
  logic signed [QW:0] tmax_x;
  logic               win;
  logic               v1_r, ok1_r;
  logic signed [CW-1:0] t1_r, oa1_r, ob1_r, da1_r, db1_r;

  always_comb begin
    t_full = in_neg ? -$signed({1'b0, in_q}) : $signed({1'b0, in_q});
    tmin_x = {{(QW + 1 - CW){in_tmin[CW-1]}}, in_tmin};
    tmax_x = {{(QW + 1 - CW){in_tmax[CW-1]}}, in_tmax};
    win    = in_ok && !(t_full < tmin_x) && !(t_full > tmax_x);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok1_r <= win;
      t1_r  <= t_full[CW-1:0];
      oa1_r <= in_oa;
      ob1_r <= in_ob;
      da1_r <= in_da;
      db1_r <= in_db;
    end
  end

  // stage 2: t times the in-plane direction components
  logic signed [2*CW-1:0] pa_nxt, pb_nxt;
  logic                   v2_r, ok2_r;
  logic signed [CW-1:0]   t2_r, oa2_r, ob2_r;
  logic signed [2*CW-1:0] pa2_r, pb2_r;

  assign pa_nxt = t1_r * da1_r;
  assign pb_nxt = t1_r * db1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok2_r <= ok1_r;
      t2_r  <= t1_r;
      oa2_r <= oa1_r;
      ob2_r <= ob1_r;
      pa2_r <= pa_nxt;
      pb2_r <= pb_nxt;
    end
  end

  // stage 3: hit point at full precision, floor of the scaled product
  logic signed [PW-1:0] pa_p, pb_p;
  logic                 v3_r, ok3_r;
  logic signed [CW-1:0] t3_r;
  logic signed [PW-1:0] pa3_r, pb3_r;

  always_comb begin
    pa_p = $signed({{(PW - CW){oa2_r[CW-1]}}, oa2_r})
         + $signed({pa2_r[2*CW-1], pa2_r[2*CW-1:FB]});
    pb_p = $signed({{(PW - CW){ob2_r[CW-1]}}, ob2_r})
         + $signed({pb2_r[2*CW-1], pb2_r[2*CW-1:FB]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok3_r <= ok2_r;
      t3_r  <= t2_r;
      pa3_r <= pa_p;
      pb3_r <= pb_p;
    end
  end

  // stage 4: map to u and v, bounds test, offsets and spans
  logic signed [PW-1:0] pu, pv, lou, hiu, lov, hiv, du, dv;
  logic signed [CW:0]   su, sv;
  logic                 inside_uv;
  logic                 v4_r, hit4_r, zu4_r, zv4_r;
  logic signed [CW-1:0] t4_r;
  logic [CW:0]          nu4_r, su4_r, nv4_r, sv4_r;

  always_comb begin
    case (axis)
      AXIS_YZ: begin
        pu  = pb3_r;
        pv  = pa3_r;
        lou = PW'(lo_i[2]);
        hiu = PW'(hi_i[2]);
        lov = PW'(lo_i[1]);
        hiv = PW'(hi_i[1]);
      end
      AXIS_XZ: begin
        pu  = pb3_r;
        pv  = pa3_r;
        lou = PW'(lo_i[2]);
        hiu = PW'(hi_i[2]);
        lov = PW'(lo_i[0]);
        hiv = PW'(hi_i[0]);
      end
      default: begin
        pu  = pa3_r;
        pv  = pb3_r;
        lou = PW'(lo_i[0]);
        hiu = PW'(hi_i[0]);
        lov = PW'(lo_i[1]);
        hiv = PW'(hi_i[1]);
      end
    endcase
    inside_uv = !(pu < lou) && !(pu > hiu) && !(pv < lov) && !(pv > hiv);
    du = pu - lou;
    dv = pv - lov;
    su = hiu[CW:0] - lou[CW:0];
    sv = hiv[CW:0] - lov[CW:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit4_r <= ok3_r && inside_uv;
      t4_r   <= t3_r;
      nu4_r  <= du[CW:0];
      su4_r  <= su;
      zu4_r  <= (su == '0);
      nv4_r  <= dv[CW:0];
      sv4_r  <= sv;
      zv4_r  <= (sv == '0);
    end
  end

  assign out_valid  = v4_r;
  assign out_hit    = hit4_r;
  assign out_t      = t4_r;
  assign out_num_u  = nu4_r;
  assign out_span_u = su4_r;
  assign out_zero_u = zu4_r;
  assign out_num_v  = nv4_r;
  assign out_span_v = sv4_r;
  assign out_zero_v = zv4_r;

endmodule

@@ rtl/core/ray_axis_rect_intersect_core.sv @@
// top level of the ray versus axis-aligned rectangle intersection core
// One ray request enters per cycle while in_stall is low, and one result leaves
// per request, in order. The path runs through two bit-per-stage divider
// pipelines (32-bit Q16.16 by default): one forms t, the other pair forms u
// and v. The whole pipeline holds while a result waits at the output, so
// in_stall follows out_stall when the output register is full. The user must
// write configuration only while no request is in flight (not enforced here).
module ray_axis_rect_intersect_core import rari_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int FB = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CW-1:0]        cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [CW-1:0] in_origin_x,
  input  logic signed [CW-1:0] in_origin_y,
  input  logic signed [CW-1:0] in_origin_z,
  input  logic signed [CW-1:0] in_dir_x,
  input  logic signed [CW-1:0] in_dir_y,
  input  logic signed [CW-1:0] in_dir_z,
  input  logic signed [CW-1:0] in_t_min,
  input  logic signed [CW-1:0] in_t_max,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_hit_found,
  output logic signed [CW-1:0] out_hit_t,
  output logic [UV_W-1:0]      out_hit_u,
  output logic [UV_W-1:0]      out_hit_v
);

  localparam int QW  = CW + 1 + FB;
  localparam int PTW = 2 + 6 * CW;
  localparam int UNW = CW + 1 + UV_FRAC;
  localparam int UDW = CW + 1;
  localparam int UPW = 2 + CW;

  logic en;

  // configuration registers
  logic [1:0]           axis_r;
  logic signed [CW-1:0] offset_r;
  logic signed [CW-1:0] lo_r [3];
  logic signed [CW-1:0] hi_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r   <= AXIS_XY;
      offset_r <= '0;
      for (int i = 0; i < 3; i++) begin
        lo_r[i] <= '0;
        hi_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PLANE_AXIS:   axis_r   <= cfg_wdata[1:0];
        REG_PLANE_OFFSET: offset_r <= cfg_wdata;
        REG_RECT_X_LOW:   lo_r[0]  <= cfg_wdata;
        REG_RECT_X_HIGH:  hi_r[0]  <= cfg_wdata;
        REG_RECT_Y_LOW:   lo_r[1]  <= cfg_wdata;
        REG_RECT_Y_HIGH:  hi_r[1]  <= cfg_wdata;
        REG_RECT_Z_LOW:   lo_r[2]  <= cfg_wdata;
        REG_RECT_Z_HIGH:  hi_r[2]  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // global advance: hold everything while a finished result is stalled
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // front stage: pick the normal axis, form |k - o| and |d|
  logic signed [CW-1:0] on, dn, oa, ob, da, db;
  logic                 ax_ok;
  logic signed [CW:0]   diff;
  logic [CW:0]          diff_mag;
  logic [CW-1:0]        d_mag;

  always_comb begin
    ax_ok = 1'b1;
    case (axis_r)
      AXIS_XY: begin
        on = in_origin_z; dn = in_dir_z;
        oa = in_origin_x; da = in_dir_x;
        ob = in_origin_y; db = in_dir_y;
      end
      AXIS_YZ: begin
        on = in_origin_x; dn = in_dir_x;
        oa = in_origin_y; da = in_dir_y;
        ob = in_origin_z; db = in_dir_z;
      end
      AXIS_XZ: begin
        on = in_origin_y; dn = in_dir_y;
        oa = in_origin_x; da = in_dir_x;
        ob = in_origin_z; db = in_dir_z;
      end
      default: begin
        ax_ok = 1'b0;
        on = in_origin_z; dn = in_dir_z;
        oa = in_origin_x; da = in_dir_x;
        ob = in_origin_y; db = in_dir_y;
      end
    endcase
    diff     = $signed({offset_r[CW-1], offset_r}) - $signed({on[CW-1], on});
    diff_mag = diff[CW] ? $unsigned(-diff) : $unsigned(diff);
    d_mag    = dn[CW-1] ? $unsigned(-dn) : $unsigned(dn);
  end

  logic                 f_v_r;
  logic [QW-1:0]        f_num_r;
  logic [CW-1:0]        f_den_r;
  logic [PTW-1:0]       f_pay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (en) begin
      f_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_num_r <= {diff_mag, {FB{1'b0}}};
      f_den_r <= d_mag;
      f_pay_r <= {ax_ok && (dn != '0), diff[CW] ^ dn[CW-1],
                  oa, ob, da, db, in_t_min, in_t_max};
    end
  end

  // t divider
  logic           td_v;
  logic [QW-1:0]  td_q;
  logic [PTW-1:0] td_pay;

  rari_div #(.NUM_W(QW), .DEN_W(CW), .PAY_W(PTW)) u_div_t (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (f_v_r),
    .num      (f_num_r),
    .den      (f_den_r),
    .pay      (f_pay_r),
    .out_valid(td_v),
    .quot     (td_q),
    .pay_out  (td_pay)
  );

  // window, hit point and bounds
  logic                 h_v, h_hit, h_zu, h_zv;
  logic signed [CW-1:0] h_t;
  logic [CW:0]          h_nu, h_su, h_nv, h_sv;

  rari_hit #(.CW(CW), .FB(FB), .QW(QW)) u_hit (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .axis      (axis_r),
    .lo_i      (lo_r),
    .hi_i      (hi_r),
    .in_valid  (td_v),
    .in_ok     (td_pay[PTW-1]),
    .in_neg    (td_pay[PTW-2]),
    .in_q      (td_q),
    .in_oa     (td_pay[6*CW-1:5*CW]),
    .in_ob     (td_pay[5*CW-1:4*CW]),
    .in_da     (td_pay[4*CW-1:3*CW]),
    .in_db     (td_pay[3*CW-1:2*CW]),
    .in_tmin   (td_pay[2*CW-1:CW]),
    .in_tmax   (td_pay[CW-1:0]),
    .out_valid (h_v),
    .out_hit   (h_hit),
    .out_t     (h_t),
    .out_num_u (h_nu),
    .out_span_u(h_su),
    .out_zero_u(h_zu),
    .out_num_v (h_nv),
    .out_span_v(h_sv),
    .out_zero_v(h_zv)
  );

  // surface coordinate dividers
  logic           ud_v, vd_v;
  logic [UNW-1:0] ud_q, vd_q;
  logic [UPW-1:0] ud_pay;
  logic           vd_pay;

  rari_div #(.NUM_W(UNW), .DEN_W(UDW), .PAY_W(UPW)) u_div_u (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (h_v),
    .num      ({h_nu, {UV_FRAC{1'b0}}}),
    .den      (h_su),
    .pay      ({h_hit, h_zu, h_t}),
    .out_valid(ud_v),
    .quot     (ud_q),
    .pay_out  (ud_pay)
  );

  rari_div #(.NUM_W(UNW), .DEN_W(UDW), .PAY_W(1)) u_div_v (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (h_v),
    .num      ({h_nv, {UV_FRAC{1'b0}}}),
    .den      (h_sv),
    .pay      (h_zv),
    .out_valid(vd_v),
    .quot     (vd_q),
    .pay_out  (vd_pay)
  );

  // output register
  logic                 out_valid_r, hit_r;
  logic signed [CW-1:0] t_r;
  logic [UV_W-1:0]      u_r, v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ud_v && vd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= ud_pay[UPW-1];
      t_r   <= ud_pay[UPW-1] ? ud_pay[CW-1:0] : '0;
      u_r   <= (ud_pay[UPW-1] && !ud_pay[UPW-2]) ? ud_q[UV_W-1:0] : '0;
      v_r   <= (ud_pay[UPW-1] && !vd_pay) ? vd_q[UV_W-1:0] : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit_found = hit_r;
  assign out_hit_t     = t_r;
  assign out_hit_u     = u_r;
  assign out_hit_v     = v_r;

endmodule

@@ rtl/core/rari_checker.sv @@
// port-level checks for the intersection core, bound to the top level
module rari_checker import rari_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_hit_found,
  input logic signed [CW-1:0] out_hit_t,
  input logic [UV_W-1:0]      out_hit_u,
  input logic [UV_W-1:0]      out_hit_v
);

  localparam logic [UV_W-1:0] UV_ONE = UV_W'(1) << UV_FRAC;

  // a miss carries all-zero payload
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit_found |->
      out_hit_t == '0 && out_hit_u == '0 && out_hit_v == '0)
    else $error("miss result with nonzero payload");

  // surface coordinates never exceed one
  a_uv_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hit_u <= UV_ONE && out_hit_v <= UV_ONE)
    else $error("surface coordinate above one");

  // input is held back only while a result waits at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit_t)
      && $stable(out_hit_found))
    else $error("stalled result changed");

  // nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ray_axis_rect_intersect_core rari_checker #(.CW(CW)) u_rari_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_hit_found(out_hit_found),
  .out_hit_t    (out_hit_t),
  .out_hit_u    (out_hit_u),
  .out_hit_v    (out_hit_v)
);
